// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds at every rising edge of clk outside reset.
`define ASSERT_IMPLY(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Checks that a condition never holds at a rising edge of clk outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- rtl/core/dnwd_pkg.sv -----
// ---------------------------------------------------------------------------
// dnwd_pkg
// Types and constants shared by the DNS name wire decoder modules.
// ---------------------------------------------------------------------------
package dnwd_pkg;

    // Field widths.
    localparam int BYTE_W   = 8;
    localparam int LIMIT_W  = 10;
    localparam int COUNT_W  = 10;
    localparam int NREAD_W  = 9;
    localparam int LABEL_W  = 6;

    // Protocol constants.
    localparam logic [BYTE_W-1:0]  MAX_LABEL    = 8'd63;
    localparam logic [COUNT_W-1:0] MAX_NAME     = 10'd255;
    localparam logic [BYTE_W-1:0]  DOT_CHAR     = 8'h2E;
    localparam logic [BYTE_W-1:0]  UPPER_A      = 8'h41;
    localparam logic [BYTE_W-1:0]  UPPER_Z      = 8'h5A;
    localparam logic [BYTE_W-1:0]  CASE_BIT     = 8'h20;
    localparam logic [COUNT_W-1:0] RAW_SAT      = 10'h3FF;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 10'd256;

    // Command queue sizing.
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = 2;
    localparam int Q_CNT_W  = 3;

    // Error codes carried on error_kind.
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_LABEL = 2'd1,
        ERR_LIMIT = 2'd2,
        ERR_NAME  = 2'd3
    } err_t;

    // Parser phase, one-hot.
    typedef enum logic [2:0] {
        PH_LEN     = 3'b001,
        PH_LABEL   = 3'b010,
        PH_DISCARD = 3'b100
    } phase_t;

    // One command from the parser: a first result and an optional second
    // result, which is either a dot or an output limit error.
    typedef struct packed {
        logic [BYTE_W-1:0]  byte1;
        logic               last1;
        err_t               err1;
        logic [NREAD_W-1:0] nread1;
        logic               has2;
        logic               second_err;
    } cmd_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

endpackage

// ----- rtl/core/dnwd_front.sv -----
// ---------------------------------------------------------------------------
// dnwd_front
// Accepts raw wire bytes, tracks the label parser and turns label bytes and
// the end of each name into commands for the result expander.
// ---------------------------------------------------------------------------
module dnwd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [dnwd_pkg::BYTE_W-1:0]   in_byte,
    input  logic                          first_of_name,
    input  logic                          cfg_wr_en,
    input  logic [dnwd_pkg::LIMIT_W-1:0]  cfg_wr_data,
    input  dnwd_pkg::q_stat_t             q_stat,
    output logic                          q_push,
    output dnwd_pkg::cmd_t                q_cmd
);
    import dnwd_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [LABEL_W-1:0] label_left_reg, label_left_next;
    logic [COUNT_W-1:0] text_count_reg, text_count_next;
    logic [COUNT_W-1:0] raw_count_reg, raw_count_next;
    logic [LIMIT_W-1:0] out_limit_reg;

    phase_t             ph;
    logic [LABEL_W-1:0] ll;
    logic [LABEL_W-1:0] ll_dec;
    logic [COUNT_W-1:0] tc;
    logic [COUNT_W-1:0] tc_inc;
    logic [COUNT_W-1:0] rc;
    logic [COUNT_W-1:0] rc_inc;
    logic [BYTE_W-1:0]  low_char;
    logic               accept;

    // Output limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            out_limit_reg <= cfg_wr_data;
        end
    end

    // Parser state after an optional restart by first_of_name.
    always_comb
    begin
        accept   = push && !q_stat.full;
        ph       = first_of_name ? PH_LEN : phase_reg;
        ll       = first_of_name ? '0 : label_left_reg;
        tc       = first_of_name ? '0 : text_count_reg;
        rc       = first_of_name ? '0 : raw_count_reg;
        rc_inc   = (rc == RAW_SAT) ? rc : rc + COUNT_W'(1);
        tc_inc   = tc + COUNT_W'(1);
        ll_dec   = ll - LABEL_W'(1);
        low_char = ((in_byte >= UPPER_A) && (in_byte <= UPPER_Z)) ?
                   (in_byte | CASE_BIT) : in_byte;
    end

    // Classify the byte and compute the next parser state.
    always_comb
    begin
        phase_next      = phase_reg;
        label_left_next = label_left_reg;
        text_count_next = text_count_reg;
        raw_count_next  = raw_count_reg;
        q_push          = 1'b0;
        q_cmd           = '0;
        q_cmd.err1      = ERR_NONE;
        if (accept)
        begin
            phase_next      = ph;
            label_left_next = ll;
            text_count_next = tc;
            raw_count_next  = rc;
            case (ph)
                PH_LEN:
                begin
                    raw_count_next = rc_inc;
                    if (in_byte == '0)
                    begin
                        q_push          = 1'b1;
                        q_cmd.last1     = 1'b1;
                        phase_next      = PH_DISCARD;
                        label_left_next = '0;
                        if (tc > MAX_NAME)
                        begin
                            q_cmd.err1 = ERR_NAME;
                        end
                        else if (tc >= out_limit_reg)
                        begin
                            q_cmd.err1 = ERR_LIMIT;
                        end
                        else
                        begin
                            q_cmd.nread1 = rc_inc[NREAD_W-1:0];
                        end
                    end
                    else if (in_byte > MAX_LABEL)
                    begin
                        q_push          = 1'b1;
                        q_cmd.last1     = 1'b1;
                        q_cmd.err1      = ERR_LABEL;
                        phase_next      = PH_DISCARD;
                        label_left_next = '0;
                    end
                    else
                    begin
                        label_left_next = in_byte[LABEL_W-1:0];
                        phase_next      = PH_LABEL;
                    end
                end
                PH_LABEL:
                begin
                    raw_count_next = rc_inc;
                    q_push         = 1'b1;
                    if (tc >= out_limit_reg)
                    begin
                        q_cmd.last1     = 1'b1;
                        q_cmd.err1      = ERR_LIMIT;
                        phase_next      = PH_DISCARD;
                        label_left_next = '0;
                    end
                    else
                    begin
                        q_cmd.byte1     = low_char;
                        text_count_next = tc_inc;
                        label_left_next = ll_dec;
                        if (ll_dec == '0)
                        begin
                            // Label complete: a dot follows unless it would
                            // overrun the output limit.
                            q_cmd.has2 = 1'b1;
                            if (tc_inc >= out_limit_reg)
                            begin
                                q_cmd.second_err = 1'b1;
                                phase_next       = PH_DISCARD;
                            end
                            else
                            begin
                                text_count_next = tc_inc + COUNT_W'(1);
                                phase_next      = PH_LEN;
                            end
                        end
                    end
                end
                default:
                begin
                    // Discarding: the byte is dropped without a result.
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LEN;
            label_left_reg <= '0;
            text_count_reg <= '0;
            raw_count_reg  <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            label_left_reg <= label_left_next;
            text_count_reg <= text_count_next;
            raw_count_reg  <= raw_count_next;
        end
    end

endmodule

// ----- rtl/core/dnwd_queue.sv -----
// ---------------------------------------------------------------------------
// dnwd_queue
// Short command queue between the parser and the result expander.
// ---------------------------------------------------------------------------
module dnwd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  dnwd_pkg::cmd_t    wr_cmd,
    input  logic              rd_en,
    output dnwd_pkg::cmd_t    rd_cmd,
    output dnwd_pkg::q_stat_t stat
);
    import dnwd_pkg::*;

    cmd_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_wr;
    logic               do_rd;

    // Pointer and fill count update.
    always_comb
    begin
        stat.valid  = (count_reg != '0);
        stat.full   = (count_reg == Q_CNT_W'(Q_DEPTH));
        do_wr       = wr_en && !stat.full;
        do_rd       = rd_en && stat.valid;
        wr_ptr_next = do_wr ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
        rd_cmd = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ----- rtl/core/dnwd_back.sv -----
// ---------------------------------------------------------------------------
// dnwd_back
// Expands each queued command into one or two result transactions and holds
// the oldest result in the output register.
// ---------------------------------------------------------------------------
module dnwd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dnwd_pkg::q_stat_t             q_stat,
    input  dnwd_pkg::cmd_t                q_cmd,
    output logic                          q_pop,
    input  logic                          pop,
    output logic                          empty,
    output logic [dnwd_pkg::BYTE_W-1:0]   out_byte,
    output logic                          is_last,
    output logic [1:0]                    error_kind,
    output logic [dnwd_pkg::NREAD_W-1:0]  bytes_read,
    output logic                          second_pending
);
    import dnwd_pkg::*;

    logic               out_valid_reg, out_valid_next;
    logic               half_reg, half_next;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic               last_reg, last_next;
    err_t               err_reg, err_next;
    logic [NREAD_W-1:0] nread_reg, nread_next;
    logic               slot_free;

    // Load the next result when the output register is free or being taken.
    always_comb
    begin
        slot_free      = !out_valid_reg || pop;
        out_valid_next = out_valid_reg;
        half_next      = half_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        err_next       = err_reg;
        nread_next     = nread_reg;
        q_pop          = 1'b0;
        if (slot_free)
        begin
            out_valid_next = q_stat.valid;
            if (q_stat.valid)
            begin
                if (half_reg)
                begin
                    // Second result of the command: dot or limit error.
                    byte_next  = q_cmd.second_err ? '0 : DOT_CHAR;
                    last_next  = q_cmd.second_err;
                    err_next   = q_cmd.second_err ? ERR_LIMIT : ERR_NONE;
                    nread_next = '0;
                    half_next  = 1'b0;
                    q_pop      = 1'b1;
                end
                else
                begin
                    byte_next  = q_cmd.byte1;
                    last_next  = q_cmd.last1;
                    err_next   = q_cmd.err1;
                    nread_next = q_cmd.nread1;
                    half_next  = q_cmd.has2;
                    q_pop      = !q_cmd.has2;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        err_reg   <= err_next;
        nread_reg <= nread_next;
    end

    assign empty          = !out_valid_reg;
    assign out_byte       = byte_reg;
    assign is_last        = last_reg;
    assign error_kind     = err_reg;
    assign bytes_read     = nread_reg;
    assign second_pending = half_reg;

endmodule

// ----- rtl/core/dns_name_wire_decoder_unit.sv -----
// ---------------------------------------------------------------------------
// dns_name_wire_decoder_unit
// Decodes a DNS wire-format name into lower-cased dotted text.
// ---------------------------------------------------------------------------
// Usage:
// The input side is a queue: drive in_byte and first_of_name and raise push;
// a transaction happens at a clock edge with push high and full low. Set
// first_of_name on the first byte of each name.
// The result side is a queue too: while empty is low the oldest result is on
// out_byte, is_last, error_kind and bytes_read, and it is taken at an edge
// with pop high. Each name ends in one result with is_last set.
// cfg_wr_en with cfg_wr_data writes the output limit; write it only while
// the block is idle.
// A transaction's command is written into the command queue; its first
// result is then loaded into the output register. Throughput is one byte per
// cycle while full is low; the last byte of a label yields two results.
// A four-entry command queue between parser and expander absorbs that and
// short receiver stalls; when it fills, full rises until pop resumes.
// Reset clears the parser, the queue and the output register and sets the
// output limit to 256.
// ---------------------------------------------------------------------------
module dns_name_wire_decoder_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [dnwd_pkg::BYTE_W-1:0]   in_byte,
    input  logic                          first_of_name,
    input  logic                          cfg_wr_en,
    input  logic [dnwd_pkg::LIMIT_W-1:0]  cfg_wr_data,
    output logic                          empty,
    input  logic                          pop,
    output logic [dnwd_pkg::BYTE_W-1:0]   out_byte,
    output logic                          is_last,
    output logic [1:0]                    error_kind,
    output logic [dnwd_pkg::NREAD_W-1:0]  bytes_read
);
    import dnwd_pkg::*;

`include "assert_macros.svh"

    q_stat_t q_stat;
    cmd_t    push_cmd;
    cmd_t    head_cmd;
    logic    q_push;
    logic    q_pop;
    logic    second_pending;

    // Parser front end.
    dnwd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .in_byte       (in_byte),
        .first_of_name (first_of_name),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    // Command queue.
    dnwd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_cmd (push_cmd),
        .rd_en  (q_pop),
        .rd_cmd (head_cmd),
        .stat   (q_stat)
    );

    // Result expander and output register.
    dnwd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_stat         (q_stat),
        .q_cmd          (head_cmd),
        .q_pop          (q_pop),
        .pop            (pop && !empty),
        .empty          (empty),
        .out_byte       (out_byte),
        .is_last        (is_last),
        .error_kind     (error_kind),
        .bytes_read     (bytes_read),
        .second_pending (second_pending)
    );

    assign full = q_stat.full;

    // The parser never writes a command into a full queue.
    `ASSERT_NEVER(a_no_push_when_full, q_push && q_stat.full, "command pushed into full queue")

    // Every error result ends its name.
    `ASSERT_IMPLY(a_err_is_last, !empty && (error_kind != ERR_NONE), is_last,
        "error result without is_last")

    // A byte count appears only on a successful terminator.
    `ASSERT_IMPLY(a_nread_on_term, !empty && (bytes_read != '0),
        is_last && (error_kind == ERR_NONE) && (out_byte == '0),
        "bytes_read set on a result other than a good terminator")

    // The second half of a command needs that command still at the queue head.
    `ASSERT_IMPLY(a_pending_has_head, second_pending, q_stat.valid,
        "second result pending with an empty queue")

endmodule
